>>> sv/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg: shared types and constants for the cartesian to spherical unit
// Point and result beats, per-cell vector, sideband records, arctangent table
// and the fixed-point helpers used by both CORDIC passes.
// ----------------------------------------------------------------------------
package c2s_pkg;

	localparam int COORD_W    = 16;
	localparam int FRAC_BITS  = 60 - COORD_W;
	localparam int DW         = 62;
	localparam int ANG_W      = 33;
	localparam int TABLE_LEN  = 32;
	localparam int AZ_W       = 17;
	localparam int EL_W       = 16;
	localparam int OUT_SHIFT  = 16;
	localparam int RND_W      = ANG_W + 1 - OUT_SHIFT;

	localparam int MAG_W      = DW - 1;
	localparam int GAIN_W     = 24;
	localparam int GAIN_SHIFT = 24;
	localparam int GAIN_PARTS = 3;
	localparam int CH_W       = (MAG_W + GAIN_PARTS - 1) / GAIN_PARTS;
	localparam int PROD_W     = CH_W + GAIN_W;
	localparam int SUM_W      = GAIN_PARTS * CH_W + GAIN_W;
	localparam logic [GAIN_W-1:0] INV_GAIN = GAIN_W'(10188014);

	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(1073741824);
	localparam logic signed [RND_W-1:0] ANG_PI      = RND_W'(32768);

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
	} point_t;

	typedef struct packed {
		logic signed [AZ_W-1:0] azimuth;
		logic        [EL_W-1:0] elevation;
	} result_t;

	typedef struct packed {
		logic signed [DW-1:0]    x;
		logic signed [DW-1:0]    y;
		logic signed [ANG_W-1:0] ang;
	} vec_t;

	// sideband through the azimuth pass
	typedef struct packed {
		logic signed [COORD_W-1:0] coord_z;
		logic                      nz_xy;
	} side1_t;

	// sideband through the gain stages
	typedef struct packed {
		logic signed [COORD_W-1:0] coord_z;
		logic                      nz_xy;
		logic signed [AZ_W-1:0]    az;
	} gside_t;

	// sideband through the elevation pass
	typedef struct packed {
		logic signed [AZ_W-1:0] az;
		logic                   el_zero;
	} side2_t;

	function automatic logic signed [DW-1:0] scale_coord(logic signed [COORD_W-1:0] c);
		logic signed [DW-1:0] v;
		v = DW'(c);
		return v <<< FRAC_BITS;
	endfunction

	// round to nearest output unit, ties round up
	function automatic logic signed [RND_W-1:0] round_angle(logic signed [ANG_W-1:0] a);
		logic signed [ANG_W:0] s;
		s = (ANG_W+1)'(a) + (ANG_W+1)'(32768);
		return s[ANG_W:OUT_SHIFT];
	endfunction

	// atan(2^-i), pi = 2^31
	function automatic logic signed [ANG_W-1:0] atan_lut(logic [4:0] i);
		logic signed [ANG_W-1:0] r;
		case (i)
			5'd0:    r = ANG_W'(536870912);
			5'd1:    r = ANG_W'(316933406);
			5'd2:    r = ANG_W'(167458907);
			5'd3:    r = ANG_W'(85004756);
			5'd4:    r = ANG_W'(42667331);
			5'd5:    r = ANG_W'(21354465);
			5'd6:    r = ANG_W'(10679838);
			5'd7:    r = ANG_W'(5340245);
			5'd8:    r = ANG_W'(2670163);
			5'd9:    r = ANG_W'(1335087);
			5'd10:   r = ANG_W'(667544);
			5'd11:   r = ANG_W'(333772);
			5'd12:   r = ANG_W'(166886);
			5'd13:   r = ANG_W'(83443);
			5'd14:   r = ANG_W'(41722);
			5'd15:   r = ANG_W'(20861);
			5'd16:   r = ANG_W'(10430);
			5'd17:   r = ANG_W'(5215);
			5'd18:   r = ANG_W'(2608);
			5'd19:   r = ANG_W'(1304);
			5'd20:   r = ANG_W'(652);
			5'd21:   r = ANG_W'(326);
			5'd22:   r = ANG_W'(163);
			5'd23:   r = ANG_W'(81);
			5'd24:   r = ANG_W'(41);
			5'd25:   r = ANG_W'(20);
			5'd26:   r = ANG_W'(10);
			5'd27:   r = ANG_W'(5);
			5'd28:   r = ANG_W'(3);
			5'd29:   r = ANG_W'(1);
			5'd30:   r = ANG_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> sv/cartesian_to_spherical_angles_unit.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical_angles_unit: azimuth and elevation of a 3-D point
// Path from the start beat to the done beat, N = stage count (up to 32): two
// N-cell CORDIC chains, two pre-rotation registers, two gain multiply stages
// and the output register. Throughput: one beat per cycle;
// busy stays low. Reset clears every valid flag; beats in flight are dropped.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_angles_unit #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  c2s_pkg::point_t   point,
	output logic              done,
	output c2s_pkg::result_t  result
);

	localparam int N_STAGES = (CORDIC_STAGES > c2s_pkg::TABLE_LEN) ?
		c2s_pkg::TABLE_LEN : CORDIC_STAGES;
	localparam int LAT = 2 * N_STAGES + 5;

	logic                                accept;
	c2s_pkg::side1_t                     side1;
	logic                                p1_valid;
	c2s_pkg::vec_t                       p1_vec;
	logic [$bits(c2s_pkg::side1_t)-1:0]  p1_side;
	c2s_pkg::side1_t                     p1_sd;
	logic signed [c2s_pkg::RND_W-1:0]    az_rnd;
	logic signed [c2s_pkg::AZ_W-1:0]     az_val;
	c2s_pkg::gside_t                     gside;
	logic                                g_valid;
	logic signed [c2s_pkg::DW-1:0]       g_h;
	logic [$bits(c2s_pkg::gside_t)-1:0]  g_side;
	c2s_pkg::gside_t                     g_sd;
	logic signed [c2s_pkg::DW-1:0]       h_eff;
	c2s_pkg::side2_t                     side2;
	logic                                p2_valid;
	c2s_pkg::vec_t                       p2_vec;
	logic [$bits(c2s_pkg::side2_t)-1:0]  p2_side;
	c2s_pkg::side2_t                     p2_sd;
	logic signed [c2s_pkg::RND_W-1:0]    el_rnd;
	logic [c2s_pkg::EL_W-1:0]            el_val;
	logic                                done_q;
	c2s_pkg::result_t                    result_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign side1.coord_z = point.coord_z;
	assign side1.nz_xy   = (point.coord_x != '0) || (point.coord_y != '0);

	c2s_pass #(
		.N_STAGES (N_STAGES),
		.SIDE_W   ($bits(c2s_pkg::side1_t))
	) u_pass_az (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (accept),
		.up_x     (c2s_pkg::scale_coord(point.coord_x)),
		.up_y     (c2s_pkg::scale_coord(point.coord_y)),
		.up_side  (side1),
		.dn_valid (p1_valid),
		.dn_vec   (p1_vec),
		.dn_side  (p1_side)
	);

	assign p1_sd  = c2s_pkg::side1_t'(p1_side);
	assign az_rnd = c2s_pkg::round_angle(p1_vec.ang);

	// origin in the plane gives zero azimuth; saturate to +/-pi otherwise
	always_comb begin
		if (!p1_sd.nz_xy) begin
			az_val = '0;
		end else if (az_rnd < -c2s_pkg::ANG_PI) begin
			az_val = c2s_pkg::AZ_W'(-c2s_pkg::ANG_PI);
		end else if (az_rnd > c2s_pkg::ANG_PI) begin
			az_val = c2s_pkg::AZ_W'(c2s_pkg::ANG_PI);
		end else begin
			az_val = az_rnd[c2s_pkg::AZ_W-1:0];
		end
	end

	assign gside.coord_z = p1_sd.coord_z;
	assign gside.nz_xy   = p1_sd.nz_xy;
	assign gside.az      = az_val;

	c2s_gain #(
		.SIDE_W ($bits(c2s_pkg::gside_t))
	) u_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (p1_valid),
		.up_mag   (p1_vec.x[c2s_pkg::MAG_W-1:0]),
		.up_side  (gside),
		.dn_valid (g_valid),
		.dn_h     (g_h),
		.dn_side  (g_side)
	);

	assign g_sd          = c2s_pkg::gside_t'(g_side);
	assign h_eff         = g_sd.nz_xy ? g_h : '0;
	assign side2.az      = g_sd.az;
	assign side2.el_zero = (h_eff == '0) && (g_sd.coord_z == '0);

	c2s_pass #(
		.N_STAGES (N_STAGES),
		.SIDE_W   ($bits(c2s_pkg::side2_t))
	) u_pass_el (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (g_valid),
		.up_x     (c2s_pkg::scale_coord(g_sd.coord_z)),
		.up_y     (h_eff),
		.up_side  (side2),
		.dn_valid (p2_valid),
		.dn_vec   (p2_vec),
		.dn_side  (p2_side)
	);

	assign p2_sd  = c2s_pkg::side2_t'(p2_side);
	assign el_rnd = c2s_pkg::round_angle(p2_vec.ang);

	// point at the origin gives zero elevation; saturate to [0, pi]
	always_comb begin
		if (p2_sd.el_zero || el_rnd[c2s_pkg::RND_W-1]) begin
			el_val = '0;
		end else if (el_rnd > c2s_pkg::ANG_PI) begin
			el_val = c2s_pkg::EL_W'(c2s_pkg::ANG_PI);
		end else begin
			el_val = el_rnd[c2s_pkg::EL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= p2_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.azimuth   <= p2_sd.az;
		result_q.elevation <= el_val;
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("accepted beat did not complete after the pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("done beat without a matching start beat");

	a_az_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.azimuth >= -17'sd32768) && (result.azimuth <= 17'sd32768))
		else $error("azimuth out of range");

	a_el_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.elevation <= 16'd32768))
		else $error("elevation out of range");

	a_az_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past((point.coord_x == '0) && (point.coord_y == '0), LAT)
			|-> (result.azimuth == '0))
		else $error("azimuth not zero for a point on the z axis");
`endif

endmodule

>>> sv/c2s_cell.sv
// ----------------------------------------------------------------------------
// c2s_cell: one CORDIC vectoring micro-rotation
// Rotates the vector toward the x axis by atan(2^-STAGE), accumulates the
// angle and registers the result together with the sideband of the beat.
// ----------------------------------------------------------------------------
module c2s_cell #(
	parameter int STAGE  = 0,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	input  c2s_pkg::vec_t       up_vec,
	input  logic [SIDE_W-1:0]   up_side,
	output logic                dn_valid,
	output c2s_pkg::vec_t       dn_vec,
	output logic [SIDE_W-1:0]   dn_side
);

	localparam logic [4:0] IDX = 5'(STAGE);
	localparam logic signed [c2s_pkg::ANG_W-1:0] ATAN_I = c2s_pkg::atan_lut(IDX);

	c2s_pkg::vec_t     vec_nxt;
	logic              valid_q;
	c2s_pkg::vec_t     vec_q;
	logic [SIDE_W-1:0] side_q;

	always_comb begin
		if (!up_vec.y[c2s_pkg::DW-1]) begin
			vec_nxt.x   = up_vec.x + (up_vec.y >>> STAGE);
			vec_nxt.y   = up_vec.y - (up_vec.x >>> STAGE);
			vec_nxt.ang = up_vec.ang + ATAN_I;
		end else begin
			vec_nxt.x   = up_vec.x - (up_vec.y >>> STAGE);
			vec_nxt.y   = up_vec.y + (up_vec.x >>> STAGE);
			vec_nxt.ang = up_vec.ang - ATAN_I;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		vec_q  <= vec_nxt;
		side_q <= up_side;
	end

	assign dn_valid = valid_q;
	assign dn_vec   = vec_q;
	assign dn_side  = side_q;

endmodule

>>> sv/c2s_pass.sv
// ----------------------------------------------------------------------------
// c2s_pass: one full CORDIC vectoring pass
// Registered quadrant pre-rotation followed by a chain of rotation cells.
// Returns the angle of (x, y) and the gain-scaled magnitude in vec.x.
// ----------------------------------------------------------------------------
module c2s_pass #(
	parameter int N_STAGES = 16,
	parameter int SIDE_W   = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        up_valid,
	input  logic signed [c2s_pkg::DW-1:0] up_x,
	input  logic signed [c2s_pkg::DW-1:0] up_y,
	input  logic [SIDE_W-1:0]           up_side,
	output logic                        dn_valid,
	output c2s_pkg::vec_t               dn_vec,
	output logic [SIDE_W-1:0]           dn_side
);

	c2s_pkg::vec_t     pre_nxt;
	logic              pre_valid_q;
	c2s_pkg::vec_t     pre_vec_q;
	logic [SIDE_W-1:0] pre_side_q;

	logic              chain_valid [N_STAGES+1];
	c2s_pkg::vec_t     chain_vec   [N_STAGES+1];
	logic [SIDE_W-1:0] chain_side  [N_STAGES+1];

	// turn a left-half-plane vector by a quarter turn
	always_comb begin
		pre_nxt.x   = up_x;
		pre_nxt.y   = up_y;
		pre_nxt.ang = '0;
		if (up_x[c2s_pkg::DW-1]) begin
			if (!up_y[c2s_pkg::DW-1]) begin
				pre_nxt.x   = up_y;
				pre_nxt.y   = -up_x;
				pre_nxt.ang = c2s_pkg::ANG_HALF_PI;
			end else begin
				pre_nxt.x   = -up_y;
				pre_nxt.y   = up_x;
				pre_nxt.ang = -c2s_pkg::ANG_HALF_PI;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_valid_q <= 1'b0;
		end else begin
			pre_valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		pre_vec_q  <= pre_nxt;
		pre_side_q <= up_side;
	end

	assign chain_valid[0] = pre_valid_q;
	assign chain_vec[0]   = pre_vec_q;
	assign chain_side[0]  = pre_side_q;

	for (genvar i = 0; i < N_STAGES; i++) begin : g_cell
		c2s_cell #(
			.STAGE  (i),
			.SIDE_W (SIDE_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[i]),
			.up_vec   (chain_vec[i]),
			.up_side  (chain_side[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_vec   (chain_vec[i+1]),
			.dn_side  (chain_side[i+1])
		);
	end

	assign dn_valid = chain_valid[N_STAGES];
	assign dn_vec   = chain_vec[N_STAGES];
	assign dn_side  = chain_side[N_STAGES];

endmodule

>>> sv/c2s_gain.sv
// ----------------------------------------------------------------------------
// c2s_gain: CORDIC gain removal
// Multiplies the non-negative magnitude by 1/K in Q24 and truncates. The
// product is built from narrow partial products over two stages.
// ----------------------------------------------------------------------------
module c2s_gain #(
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	input  logic [c2s_pkg::MAG_W-1:0]     up_mag,
	input  logic [SIDE_W-1:0]             up_side,
	output logic                          dn_valid,
	output logic signed [c2s_pkg::DW-1:0] dn_h,
	output logic [SIDE_W-1:0]             dn_side
);

	localparam int EXT_W = c2s_pkg::GAIN_PARTS * c2s_pkg::CH_W;

	logic [EXT_W-1:0]              mag_ext;
	logic [c2s_pkg::PROD_W-1:0]    prod_s1 [c2s_pkg::GAIN_PARTS];
	logic [SIDE_W-1:0]             side_s1;
	logic                          valid_s1;
	logic [c2s_pkg::SUM_W-1:0]     sum;
	logic signed [c2s_pkg::DW-1:0] h_s2;
	logic [SIDE_W-1:0]             side_s2;
	logic                          valid_s2;

	assign mag_ext = EXT_W'(up_mag);

	always_ff @(posedge clk) begin
		for (int k = 0; k < c2s_pkg::GAIN_PARTS; k++) begin
			prod_s1[k] <= c2s_pkg::PROD_W'(mag_ext[k*c2s_pkg::CH_W +: c2s_pkg::CH_W])
				* c2s_pkg::PROD_W'(c2s_pkg::INV_GAIN);
		end
		side_s1 <= up_side;
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < c2s_pkg::GAIN_PARTS; k++) begin
			sum = sum + (c2s_pkg::SUM_W'(prod_s1[k]) << (k * c2s_pkg::CH_W));
		end
	end

	always_ff @(posedge clk) begin
		h_s2    <= sum[c2s_pkg::GAIN_SHIFT +: c2s_pkg::DW];
		side_s2 <= side_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_h     = h_s2;
	assign dn_side  = side_s2;

endmodule

>>> bench/tb_cartesian_to_spherical_angles_unit.sv
// ----------------------------------------------------------------------------
// tb_cartesian_to_spherical_angles_unit: self-checking bench for the angle unit
// Drives a short table of corner points, then random points in several shapes,
// with bursts of idle cycles on the start side. A 64-bit model of both CORDIC
// passes predicts azimuth and elevation per accepted beat, or the table row
// pins it; each done beat is compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_cartesian_to_spherical_angles_unit;

	localparam int     STAGES        = 16;
	localparam int     SCALE_SHIFT   = 60 - 16;
	localparam longint QUARTER_TURN  = 64'sd1 <<< 30;
	localparam longint INV_GAIN_Q24  = 64'sd10188014;
	localparam longint LOW24_MASK    = 64'sd16777215;
	localparam int     RANDOM_POINTS = 500;
	localparam int     CALM_TAIL     = 100;
	localparam int     DRAIN_CYCLES  = 2 * STAGES + 5 + 8;
	localparam int     STALL_LIMIT   = 1000;
	localparam int     N_DIRECTED    = 23;

	typedef struct packed {
		c2s_pkg::point_t  pt;
		logic             pinned;
		c2s_pkg::result_t res;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	c2s_pkg::point_t  point;
	logic             done;
	c2s_pkg::result_t result;

	// expectation typed into the table, handed over with the beat
	logic             pinned_valid;
	c2s_pkg::result_t pinned_result;

	c2s_pkg::result_t angles_due [$];
	c2s_pkg::result_t want;
	int               fail_count;
	int               stall_cycles;
	logic             progress;
	logic             idle_mode;

	longint atan_of_shift [0:31] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1, 1, 0
	};

	stim_row_t corner_points [N_DIRECTED] = '{
		'{'{0, 0, 0}, 1'b1, '{0, 0}},
		'{'{32767, 0, 0}, 1'b0, '0},
		'{'{-32768, 0, 0}, 1'b0, '0},
		'{'{-1, 0, 0}, 1'b0, '0},
		'{'{0, 32767, 0}, 1'b0, '0},
		'{'{0, -32768, 0}, 1'b0, '0},
		'{'{0, 0, 32767}, 1'b0, '0},
		'{'{0, 0, -32768}, 1'b0, '0},
		'{'{0, 0, 1}, 1'b0, '0},
		'{'{0, 0, -1}, 1'b0, '0},
		'{'{32767, 32767, 32767}, 1'b0, '0},
		'{'{-32768, -32768, -32768}, 1'b0, '0},
		'{'{-32768, -1, 0}, 1'b0, '0},
		'{'{-32768, 1, 5}, 1'b0, '0},
		'{'{-5, 3, -7}, 1'b0, '0},
		'{'{-5, -3, 7}, 1'b0, '0},
		'{'{32767, -32768, 0}, 1'b0, '0},
		'{'{-32768, 32767, -32768}, 1'b0, '0},
		'{'{1, 1, 1}, 1'b0, '0},
		'{'{-1, -1, -1}, 1'b0, '0},
		'{'{1, 0, 0}, 1'b0, '0},
		'{'{0, 1, -1}, 1'b0, '0},
		'{'{12345, -23456, 3210}, 1'b0, '0}
	};

	cartesian_to_spherical_angles_unit #(
		.CORDIC_STAGES(STAGES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.point  (point),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// vectoring pass: returns the angle of (vx, vy), len gets the scaled length
	function automatic longint cordic_vector(input longint vx, input longint vy,
			output longint len);
		longint ang;
		longint t;
		ang = 0;
		if (vx < 0) begin
			t = vx;
			if (vy >= 0) begin
				vx = vy;
				vy = -t;
				ang = QUARTER_TURN;
			end else begin
				vx = -vy;
				vy = t;
				ang = -QUARTER_TURN;
			end
		end
		for (int i = 0; i < STAGES && i < 32; i++) begin
			if (vy >= 0) begin
				t = vx + (vy >>> i);
				vy = vy - (vx >>> i);
				ang += atan_of_shift[i];
			end else begin
				t = vx - (vy >>> i);
				vy = vy + (vx >>> i);
				ang -= atan_of_shift[i];
			end
			vx = t;
		end
		len = vx;
		return ang;
	endfunction

	function automatic longint to_angle_units(longint ang, longint lo, longint hi);
		longint r;
		r = (ang + 32768) >>> 16;
		if (r < lo)
			r = lo;
		if (r > hi)
			r = hi;
		return r;
	endfunction

	function automatic c2s_pkg::result_t predict_angles(c2s_pkg::point_t p);
		longint           px, py, pz;
		longint           len, planar, unused_len;
		longint           az, el;
		c2s_pkg::result_t r;
		px = longint'(p.coord_x) <<< SCALE_SHIFT;
		py = longint'(p.coord_y) <<< SCALE_SHIFT;
		pz = longint'(p.coord_z) <<< SCALE_SHIFT;
		az = 0;
		el = 0;
		planar = 0;
		if (p.coord_x != 0 || p.coord_y != 0) begin
			az = to_angle_units(cordic_vector(px, py, len), -32768, 32768);
			// strip the CORDIC gain in two parts to stay inside 64 bits
			planar = (len >>> 24) * INV_GAIN_Q24
				+ (((len & LOW24_MASK) * INV_GAIN_Q24) >>> 24);
		end
		if (planar != 0 || p.coord_z != 0)
			el = to_angle_units(cordic_vector(pz, planar, unused_len), 0, 32768);
		r.azimuth   = 17'(az);
		r.elevation = 16'(el);
		return r;
	endfunction

	function automatic logic [15:0] edge_coord();
		case ($urandom_range(0, 6))
			0:       return 16'h8000;
			1:       return 16'h8001;
			2:       return 16'hFFFF;
			3:       return 16'h0000;
			4:       return 16'h0001;
			5:       return 16'h7FFE;
			default: return 16'h7FFF;
		endcase
	endfunction

	function automatic c2s_pkg::point_t random_point();
		c2s_pkg::point_t p;
		p = c2s_pkg::point_t'({$urandom, 16'($urandom)});
		case ($urandom_range(0, 7))
			3: begin
				// tiny points reach the zero-length cases
				p.coord_x = 16'($signed($urandom_range(0, 8)) - 4);
				p.coord_y = 16'($signed($urandom_range(0, 8)) - 4);
				p.coord_z = 16'($signed($urandom_range(0, 8)) - 4);
			end
			4: begin
				if ($urandom_range(0, 1)) p.coord_x = '0;
				if ($urandom_range(0, 1)) p.coord_y = '0;
				if ($urandom_range(0, 1)) p.coord_z = '0;
			end
			5: begin
				p.coord_x = edge_coord();
				p.coord_y = edge_coord();
				p.coord_z = edge_coord();
			end
			6: begin
				// hug the negative x axis, where the angle wraps
				p.coord_x = 16'(-$signed($urandom_range(1, 32768)));
				p.coord_y = 16'($signed($urandom_range(0, 4)) - 2);
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic drive_beat(c2s_pkg::point_t p, logic pin, c2s_pkg::result_t res);
		start         <= 1'b1;
		point         <= p;
		pinned_valid  <= pin;
		pinned_result <= res;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic maybe_idle(int idx, int total);
		int gap;
		if (idx % 32 == 0)
			idle_mode = 1'($urandom_range(0, 1));
		if (idx < total - CALM_TAIL && idle_mode && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic report_failure(string what, c2s_pkg::result_t exp,
			c2s_pkg::result_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%s: expected az=%0d el=%0d, got az=%0d el=%0d", what,
				exp.azimuth, exp.elevation, got.azimuth, got.elevation);
	endtask

	// monitor: predict on every accepted point, check every done beat
	always @(posedge clk) begin
		if (arst_n) begin
			progress = 1'b0;
			if (start && !busy) begin
				angles_due.insert(angles_due.size(),
					pinned_valid ? pinned_result : predict_angles(point));
				progress = 1'b1;
			end
			if (done !== 1'b0) begin
				progress = 1'b1;
				if (angles_due.size() == 0) begin
					report_failure("unexpected result", '0, result);
				end else begin
					want = angles_due.pop_front();
					if (done !== 1'b1 || result.azimuth !== want.azimuth
							|| result.elevation !== want.elevation)
						report_failure("result mismatch", want, result);
				end
			end
			stall_cycles = progress ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles", STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		point         = '0;
		pinned_valid  = 1'b0;
		pinned_result = '0;
		fail_count    = 0;
		stall_cycles  = 0;
		idle_mode     = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			maybe_idle(i, N_DIRECTED + RANDOM_POINTS);
			drive_beat(corner_points[i].pt, corner_points[i].pinned, corner_points[i].res);
		end
		for (int i = 0; i < RANDOM_POINTS; i++) begin
			maybe_idle(N_DIRECTED + i, N_DIRECTED + RANDOM_POINTS);
			drive_beat(random_point(), 1'b0, '0);
		end
		start        <= 1'b0;
		pinned_valid <= 1'b0;

		// drain the pipe, then hold to catch stray done beats
		while (angles_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
